// File: sv/vtdl_pkg.sv
// Package for the vertex transform and diffuse lighting pipeline.
// Holds the transfer payload types, register indexes and shared constants.
// No dependencies.
`default_nettype none

package vtdl_pkg;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic               corner_last;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic [15:0]        inv_depth;
        logic [15:0]        red;
        logic [15:0]        green;
        logic [15:0]        blue;
        logic               behind_camera;
        logic               strip_end;
    } t_out_item;

    typedef enum logic [2:0] {
        CFG_COS_FIRST   = 3'd0,
        CFG_SIN_FIRST   = 3'd1,
        CFG_COS_SECOND  = 3'd2,
        CFG_SIN_SECOND  = 3'd3,
        CFG_LIGHT_RED   = 3'd4,
        CFG_LIGHT_GREEN = 3'd5,
        CFG_LIGHT_BLUE  = 3'd6
    } t_cfg_index;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;
    localparam int NUM_LIGHTS = 3;
    localparam int LIGHT_W    = 20;

    localparam int SQ_STEPS  = 23;
    localparam int SQ_W      = 48;
    localparam int SQ_LANES  = 4;
    localparam int DV_STEPS  = 17;
    localparam int DV_W      = 64;
    localparam int DV_DEN_W  = 46;
    localparam int DV_LANES  = 6;

    localparam logic [15:0]        AMBIENT   = 16'd13107;
    localparam logic [16:0]        DIFFUSE   = 17'd39322;
    localparam logic [16:0]        INV_MAX   = 17'd65535;
    localparam logic signed [26:0] Z_OFFSET  = 27'sd81920;
    localparam logic signed [18:0] SX_CENTER = 19'sd5120;
    localparam logic signed [18:0] SY_CENTER = 19'sd3840;

endpackage

`default_nettype wire

// File: sv/vertex_transform_diffuse_light_unit.sv
// Top level of the vertex transform and diffuse lighting pipeline.
// Depends on vtdl_pkg for payload types, register indexes and constants.
//
//   Channel   Direction  Handshake                    Payload
//   in        input      i_in_valid / o_in_stall      vtdl_pkg::t_in_item
//   out       output     o_out_valid / i_out_stall    vtdl_pkg::t_out_item
//   cfg       input      i_cfg_valid / o_cfg_ready    index 3 bits, data 60 bits
//
// One vertex enters per cycle unless a valid output is stalled; each passes through the
// 23-step square root and the 17-step divider stages on its way from input to output.
// All stages advance together; a stalled valid output holds every stage and stalls input.
// Reset clears the valid bits and loads the register reset values.
`default_nettype none

module vertex_transform_diffuse_light_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire vtdl_pkg::t_in_item              i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output vtdl_pkg::t_out_item                  o_out_data,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [vtdl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [vtdl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NSTG   = 7 + vtdl_pkg::SQ_STEPS + 2 + vtdl_pkg::DV_STEPS + 1;
    localparam int ROOT_W = vtdl_pkg::SQ_STEPS;
    localparam int NL     = vtdl_pkg::NUM_LIGHTS;

    typedef struct packed {
        logic [NL-1:0][46:0] d;
        logic [39:0]         pnx;
        logic [39:0]         pny;
        logic                sx;
        logic                sy;
        logic [30:0]         pni;
        logic [27:0]         pd;
        logic                behind;
        logic                last;
    } t_sq_side;

    typedef struct packed {
        logic [NL-1:0] amb;
        logic          sx;
        logic          sy;
        logic          behind;
        logic          last;
    } t_dv_side;

    logic signed [15:0]                r_cos1, r_sin1, r_cos2, r_sin2;
    logic [vtdl_pkg::CFG_DATA_W-1:0]   r_light [NL];
    logic [NSTG-1:0]                   r_vld;
    logic                              en;

    logic signed [15:0] w_x0 [2], w_y0 [2], w_z0 [2];
    logic signed [31:0] r1_yc [2], r1_zs [2], r1_ys [2], r1_zc [2];
    logic signed [15:0] r1_x [2];
    logic               r1_last;
    logic signed [18:0] r2_y [2], r2_z [2];
    logic signed [15:0] r2_x [2];
    logic               r2_last;
    logic signed [34:0] r3_xc [2], r3_zs [2], r3_xs [2], r3_zc [2];
    logic signed [18:0] r3_y [2];
    logic               r3_last;
    logic signed [21:0] r4_v [2][3];
    logic               r4_last;
    logic signed [22:0] r5_l [NL][3];
    logic signed [21:0] r5_n [3];
    logic signed [25:0] r5_px, r5_py;
    logic signed [26:0] r5_pz;
    logic               r5_last;
    logic signed [44:0] r6_nl [NL][3];
    logic signed [43:0] r6_nn [3];
    logic signed [45:0] r6_ll [NL][3];
    logic signed [37:0] r6_nx, r6_ny;
    logic signed [26:0] r6_pz;
    logic               r6_last;
    logic [37:0]        w_ax, w_ay;
    logic               w_behind;
    t_sq_side           r7_side;
    logic [45:0]        r7_sq [vtdl_pkg::SQ_LANES];

    logic [vtdl_pkg::SQ_W-1:0] r_sq_rem  [vtdl_pkg::SQ_STEPS][vtdl_pkg::SQ_LANES];
    logic [ROOT_W-1:0]         r_sq_root [vtdl_pkg::SQ_STEPS][vtdl_pkg::SQ_LANES];
    t_sq_side                  r_sq_side [vtdl_pkg::SQ_STEPS];

    logic [45:0]   r_h_den [NL];
    logic [61:0]   r_h_dn [NL];
    logic [NL-1:0] r_h_amb;
    t_sq_side      r_h_side;

    logic [vtdl_pkg::DV_W-1:0]     r_dv_rem [vtdl_pkg::DV_STEPS+1][vtdl_pkg::DV_LANES];
    logic [vtdl_pkg::DV_DEN_W-1:0] r_dv_den [vtdl_pkg::DV_STEPS+1][vtdl_pkg::DV_LANES];
    logic [vtdl_pkg::DV_STEPS-1:0] r_dv_q   [vtdl_pkg::DV_STEPS+1][vtdl_pkg::DV_LANES];
    logic                          r_dv_ovf [vtdl_pkg::DV_STEPS+1][vtdl_pkg::DV_LANES];
    t_dv_side                      r_dv_side [vtdl_pkg::DV_STEPS+1];

    logic [vtdl_pkg::DV_W-1:0]     w_num [vtdl_pkg::DV_LANES];
    logic [vtdl_pkg::DV_DEN_W-1:0] w_den [vtdl_pkg::DV_LANES];
    t_dv_side                      w_dvs;

    vtdl_pkg::t_out_item r_out, n_out;

    function automatic logic signed [18:0] rnd14_a(input logic signed [32:0] v);
        logic signed [32:0] t;
        t = v + 33'sd8192;
        return t[32:14];
    endfunction

    function automatic logic signed [21:0] rnd14_b(input logic signed [35:0] v);
        logic signed [35:0] t;
        t = v + 36'sd8192;
        return t[35:14];
    endfunction

    function automatic logic [15:0] screen_val(input logic ovf, input logic neg,
                                               input logic [16:0] q,
                                               input logic signed [18:0] ctr);
        logic signed [18:0] s;
        logic [15:0]        res;
        s = (neg ? -$signed(19'(q)) : $signed(19'(q))) + ctr;
        if (ovf) begin
            res = neg ? 16'h8000 : 16'h7fff;
        end else if (s > 19'sd32767) begin
            res = 16'h7fff;
        end else if (s < -19'sd32768) begin
            res = 16'h8000;
        end else begin
            res = s[15:0];
        end
        return res;
    endfunction

    assign en          = !(r_vld[NSTG-1] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[NSTG-1];
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos1 <= 16'sd16384;
            r_sin1 <= '0;
            r_cos2 <= 16'sd16384;
            r_sin2 <= '0;
            for (int k = 0; k < NL; k++) begin
                r_light[k] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (vtdl_pkg::t_cfg_index'(i_cfg_index))
                vtdl_pkg::CFG_COS_FIRST:   r_cos1 <= i_cfg_data[15:0];
                vtdl_pkg::CFG_SIN_FIRST:   r_sin1 <= i_cfg_data[15:0];
                vtdl_pkg::CFG_COS_SECOND:  r_cos2 <= i_cfg_data[15:0];
                vtdl_pkg::CFG_SIN_SECOND:  r_sin2 <= i_cfg_data[15:0];
                vtdl_pkg::CFG_LIGHT_RED:   r_light[0] <= i_cfg_data;
                vtdl_pkg::CFG_LIGHT_GREEN: r_light[1] <= i_cfg_data;
                vtdl_pkg::CFG_LIGHT_BLUE:  r_light[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_in_valid};
        end
    end

    assign w_x0[0] = i_in_data.pos_x;
    assign w_y0[0] = i_in_data.pos_y;
    assign w_z0[0] = i_in_data.pos_z;
    assign w_x0[1] = i_in_data.norm_x;
    assign w_y0[1] = i_in_data.norm_y;
    assign w_z0[1] = i_in_data.norm_z;

    // Rotation about x, then about y, for the point and the normal.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int v = 0; v < 2; v++) begin
                r1_yc[v] <= w_y0[v] * r_cos1;
                r1_zs[v] <= w_z0[v] * r_sin1;
                r1_ys[v] <= w_y0[v] * r_sin1;
                r1_zc[v] <= w_z0[v] * r_cos1;
                r1_x[v]  <= w_x0[v];
                r2_y[v]  <= rnd14_a(33'(r1_yc[v]) - 33'(r1_zs[v]));
                r2_z[v]  <= rnd14_a(33'(r1_ys[v]) + 33'(r1_zc[v]));
                r2_x[v]  <= r1_x[v];
                r3_xc[v] <= r2_x[v] * r_cos2;
                r3_zs[v] <= r2_z[v] * r_sin2;
                r3_xs[v] <= r2_x[v] * r_sin2;
                r3_zc[v] <= r2_z[v] * r_cos2;
                r3_y[v]  <= r2_y[v];
                r4_v[v][0] <= rnd14_b(36'(r3_xc[v]) - 36'(r3_zs[v]));
                r4_v[v][1] <= 22'(r3_y[v]);
                r4_v[v][2] <= rnd14_b(36'(r3_xs[v]) + 36'(r3_zc[v]));
            end
            r1_last <= i_in_data.corner_last;
            r2_last <= r1_last;
            r3_last <= r2_last;
            r4_last <= r3_last;
        end
    end

    // Light vectors, dot products, squared lengths and the projection numerators.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < NL; k++) begin
                    r5_l[k][i] <= 23'($signed(r_light[k][vtdl_pkg::LIGHT_W*i +: vtdl_pkg::LIGHT_W]))
                                  - 23'(r4_v[0][i]);
                    r6_nl[k][i] <= r5_n[i] * r5_l[k][i];
                    r6_ll[k][i] <= r5_l[k][i] * r5_l[k][i];
                end
                r5_n[i]  <= r4_v[1][i];
                r6_nn[i] <= r5_n[i] * r5_n[i];
            end
            r5_px   <= 26'(r4_v[0][0]) * 26'sd10;
            r5_py   <= 26'(r4_v[0][1]) * 26'sd10;
            r5_pz   <= 27'(r4_v[0][2]) * 27'sd10 + vtdl_pkg::Z_OFFSET;
            r5_last <= r4_last;
            r6_nx   <= 38'(r5_px) * 38'sd3840;
            r6_ny   <= 38'(r5_py) * 38'sd3840;
            r6_pz   <= r5_pz;
            r6_last <= r5_last;
        end
    end

    assign w_ax     = r6_nx[37] ? 38'(-r6_nx) : 38'(r6_nx);
    assign w_ay     = r6_ny[37] ? 38'(-r6_ny) : 38'(r6_ny);
    assign w_behind = r6_pz[26] || (r6_pz == '0);

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NL; k++) begin
                r7_side.d[k] <= 47'(r6_nl[k][0]) + 47'(r6_nl[k][1]) + 47'(r6_nl[k][2]);
                r7_sq[k+1]   <= 46'(r6_ll[k][0]) + 46'(r6_ll[k][1]) + 46'(r6_ll[k][2]);
            end
            r7_sq[0]       <= 46'(r6_nn[0]) + 46'(r6_nn[1]) + 46'(r6_nn[2]);
            r7_side.pnx    <= 40'({w_ax, 1'b0}) + 40'(unsigned'(r6_pz));
            r7_side.pny    <= 40'({w_ay, 1'b0}) + 40'(unsigned'(r6_pz));
            r7_side.sx     <= r6_nx[37];
            r7_side.sy     <= r6_ny[37];
            r7_side.pni    <= 31'(32'd1 << 29) + 31'(unsigned'(r6_pz));
            r7_side.pd     <= w_behind ? 28'd1 : {r6_pz[26:0], 1'b0};
            r7_side.behind <= w_behind;
            r7_side.last   <= r6_last;
        end
    end

    // Integer square roots, one result bit per stage.
    always_ff @(posedge i_clk) begin
        logic [vtdl_pkg::SQ_W-1:0] v_rem;
        logic [vtdl_pkg::SQ_W-1:0] v_trial;
        logic [ROOT_W-1:0]         v_root;
        if (en) begin
            for (int j = 0; j < vtdl_pkg::SQ_STEPS; j++) begin
                if (j == 0) begin
                    r_sq_side[j] <= r7_side;
                end else begin
                    r_sq_side[j] <= r_sq_side[j-1];
                end
                for (int l = 0; l < vtdl_pkg::SQ_LANES; l++) begin
                    if (j == 0) begin
                        v_rem  = vtdl_pkg::SQ_W'(r7_sq[l]);
                        v_root = '0;
                    end else begin
                        v_rem  = r_sq_rem[j-1][l];
                        v_root = r_sq_root[j-1][l];
                    end
                    v_trial = (vtdl_pkg::SQ_W'(v_root) << (vtdl_pkg::SQ_STEPS - j))
                            + (vtdl_pkg::SQ_W'(1) << (2 * (vtdl_pkg::SQ_STEPS - 1 - j)));
                    if (v_rem >= v_trial) begin
                        v_rem  = v_rem - v_trial;
                        v_root = v_root | (ROOT_W'(1) << (vtdl_pkg::SQ_STEPS - 1 - j));
                    end
                    r_sq_rem[j][l]  <= v_rem;
                    r_sq_root[j][l] <= v_root;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NL; k++) begin
                r_h_den[k] <= 46'(r_sq_root[vtdl_pkg::SQ_STEPS-1][0])
                            * 46'(r_sq_root[vtdl_pkg::SQ_STEPS-1][k+1]);
                r_h_dn[k]  <= 62'(r_sq_side[vtdl_pkg::SQ_STEPS-1].d[k][45:0])
                            * 62'(vtdl_pkg::DIFFUSE);
                r_h_amb[k] <= r_sq_side[vtdl_pkg::SQ_STEPS-1].d[k][46]
                           || (r_sq_side[vtdl_pkg::SQ_STEPS-1].d[k] == '0)
                           || (r_sq_root[vtdl_pkg::SQ_STEPS-1][0] == '0)
                           || (r_sq_root[vtdl_pkg::SQ_STEPS-1][k+1] == '0);
            end
            r_h_side <= r_sq_side[vtdl_pkg::SQ_STEPS-1];
        end
    end

    always_comb begin
        for (int k = 0; k < NL; k++) begin
            w_num[k] = vtdl_pkg::DV_W'(r_h_dn[k]);
            w_den[k] = r_h_amb[k] ? vtdl_pkg::DV_DEN_W'(1) : r_h_den[k];
        end
        w_num[3]    = vtdl_pkg::DV_W'(r_h_side.pnx);
        w_den[3]    = vtdl_pkg::DV_DEN_W'(r_h_side.pd);
        w_num[4]    = vtdl_pkg::DV_W'(r_h_side.pny);
        w_den[4]    = vtdl_pkg::DV_DEN_W'(r_h_side.pd);
        w_num[5]    = vtdl_pkg::DV_W'(r_h_side.pni);
        w_den[5]    = vtdl_pkg::DV_DEN_W'(r_h_side.pd);
        w_dvs.amb    = r_h_amb;
        w_dvs.sx     = r_h_side.sx;
        w_dvs.sy     = r_h_side.sy;
        w_dvs.behind = r_h_side.behind;
        w_dvs.last   = r_h_side.last;
    end

    // Restoring division, one quotient bit per stage after the range check.
    always_ff @(posedge i_clk) begin
        logic [vtdl_pkg::DV_W-1:0]     v_rem;
        logic [vtdl_pkg::DV_W-1:0]     v_trial;
        logic [vtdl_pkg::DV_STEPS-1:0] v_q;
        if (en) begin
            r_dv_side[0] <= w_dvs;
            for (int l = 0; l < vtdl_pkg::DV_LANES; l++) begin
                r_dv_rem[0][l] <= w_num[l];
                r_dv_den[0][l] <= w_den[l];
                r_dv_q[0][l]   <= '0;
                r_dv_ovf[0][l] <= w_num[l]
                               >= (vtdl_pkg::DV_W'(w_den[l]) << vtdl_pkg::DV_STEPS);
            end
            for (int j = 1; j <= vtdl_pkg::DV_STEPS; j++) begin
                r_dv_side[j] <= r_dv_side[j-1];
                for (int l = 0; l < vtdl_pkg::DV_LANES; l++) begin
                    v_rem   = r_dv_rem[j-1][l];
                    v_q     = r_dv_q[j-1][l];
                    v_trial = vtdl_pkg::DV_W'(r_dv_den[j-1][l]) << (vtdl_pkg::DV_STEPS - j);
                    if (!r_dv_ovf[j-1][l] && (v_rem >= v_trial)) begin
                        v_rem = v_rem - v_trial;
                        v_q   = v_q | (vtdl_pkg::DV_STEPS'(1) << (vtdl_pkg::DV_STEPS - j));
                    end
                    r_dv_rem[j][l] <= v_rem;
                    r_dv_q[j][l]   <= v_q;
                    r_dv_den[j][l] <= r_dv_den[j-1][l];
                    r_dv_ovf[j][l] <= r_dv_ovf[j-1][l];
                end
            end
        end
    end

    always_comb begin
        logic [16:0] v_gain [NL];
        logic [15:0] v_col [NL];
        for (int k = 0; k < NL; k++) begin
            if (r_dv_ovf[vtdl_pkg::DV_STEPS][k]
                || (r_dv_q[vtdl_pkg::DV_STEPS][k] > vtdl_pkg::DIFFUSE)) begin
                v_gain[k] = vtdl_pkg::DIFFUSE;
            end else begin
                v_gain[k] = r_dv_q[vtdl_pkg::DV_STEPS][k];
            end
            v_col[k] = r_dv_side[vtdl_pkg::DV_STEPS].amb[k] ? vtdl_pkg::AMBIENT
                     : 16'(17'(vtdl_pkg::AMBIENT) + v_gain[k]);
        end
        n_out.red   = v_col[0];
        n_out.green = v_col[1];
        n_out.blue  = v_col[2];
        n_out.behind_camera = r_dv_side[vtdl_pkg::DV_STEPS].behind;
        n_out.strip_end     = r_dv_side[vtdl_pkg::DV_STEPS].last;
        if (r_dv_side[vtdl_pkg::DV_STEPS].behind) begin
            n_out.screen_x  = '0;
            n_out.screen_y  = '0;
            n_out.inv_depth = '0;
        end else begin
            n_out.screen_x = screen_val(r_dv_ovf[vtdl_pkg::DV_STEPS][3],
                                        r_dv_side[vtdl_pkg::DV_STEPS].sx,
                                        r_dv_q[vtdl_pkg::DV_STEPS][3], vtdl_pkg::SX_CENTER);
            n_out.screen_y = screen_val(r_dv_ovf[vtdl_pkg::DV_STEPS][4],
                                        r_dv_side[vtdl_pkg::DV_STEPS].sy,
                                        r_dv_q[vtdl_pkg::DV_STEPS][4], vtdl_pkg::SY_CENTER);
            if (r_dv_ovf[vtdl_pkg::DV_STEPS][5]
                || (r_dv_q[vtdl_pkg::DV_STEPS][5] > vtdl_pkg::INV_MAX)) begin
                n_out.inv_depth = 16'hffff;
            end else begin
                n_out.inv_depth = r_dv_q[vtdl_pkg::DV_STEPS][5][15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire
